### rtl/hcbd_pkg.sv
// hcbd_pkg: shared types and constants of the chunked body decoder
// no dependencies; imported by the front, queue and back modules and the top level
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;

   localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

   // framing phase of the decoder
   typedef enum logic [3:0] {
      PHASE_SIZE_START,
      PHASE_SIZE_DIGITS,
      PHASE_SIZE_LF,
      PHASE_DATA,
      PHASE_DATA_CR,
      PHASE_DATA_LF,
      PHASE_FINAL_CR,
      PHASE_FINAL_LF,
      PHASE_DONE,
      PHASE_BAD,
      PHASE_BIG
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_RUN,
      STATUS_DONE,
      STATUS_BAD,
      STATUS_BIG
   } status_type;

   // one classified input item as it travels from front to back
   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
      logic       is_cr;
      logic       is_lf;
      logic       hex_ok;
      logic [3:0] hex_val;
   } entry_type;

endpackage

`default_nettype wire

### rtl/hcbd_req_if.sv
// hcbd_req_if: input channel carrying raw body bytes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       restart;

   modport source (output valid, output in_byte, output restart, input ready);
   modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

`default_nettype wire

### rtl/hcbd_rsp_if.sv
// hcbd_rsp_if: result channel carrying payload bytes and decode status
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface hcbd_rsp_if;
   logic        valid;
   logic        ready;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic [1:0]  status;
   logic [31:0] body_count;

   modport source (output valid, output payload_valid, output payload_byte,
                   output status, output body_count, input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input status, input body_count, output ready);
endinterface

`default_nettype wire

### rtl/hcbd_csr_if.sv
// hcbd_csr_if: write channel of the body size limit register
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface hcbd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] max_body_bytes;

   modport source (output valid, output max_body_bytes, input ready);
   modport sink   (input valid, input max_body_bytes, output ready);
endinterface

`default_nettype wire

### rtl/hcbd_front.sv
// hcbd_front: accepts input items and classifies each byte (cr, lf, hex digit)
// depends on hcbd_pkg and hcbd_req_if
`timescale 1ns / 1ps
`default_nettype none

module hcbd_front (
   hcbd_req_if.sink               req_chan,
   input  logic                   queue_full,
   output logic                   push,
   output hcbd_pkg::entry_type    push_entry
);
   import hcbd_pkg::*;

   logic       hex_ok;
   logic [3:0] hex_val;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      case (req_chan.in_byte) inside
         [8'h30:8'h39]: begin
            hex_val = 4'(req_chan.in_byte - 8'h30);
         end
         [8'h41:8'h46]: begin
            hex_val = 4'(req_chan.in_byte - 8'h37);
         end
         [8'h61:8'h66]: begin
            hex_val = 4'(req_chan.in_byte - 8'h57);
         end
         default: begin
            hex_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      req_chan.ready     = !queue_full;
      push               = req_chan.valid && !queue_full;
      push_entry.in_byte = req_chan.in_byte;
      push_entry.restart = req_chan.restart;
      push_entry.is_cr   = (req_chan.in_byte == CH_CR);
      push_entry.is_lf   = (req_chan.in_byte == CH_LF);
      push_entry.hex_ok  = hex_ok;
      push_entry.hex_val = hex_val;
   end

endmodule

`default_nettype wire

### rtl/hcbd_queue.sv
// hcbd_queue: short fifo of classified items between front and back
// depends on hcbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hcbd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hcbd_pkg::entry_type push_entry,
   input  logic                pop,
   output hcbd_pkg::entry_type head_entry,
   output logic                full,
   output logic                empty
);
   import hcbd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type              slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) r = '0;
      else r = p + PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   assign head_entry = slot_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a push");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

endmodule

`default_nettype wire

### rtl/hcbd_back.sv
// hcbd_back: framing state machine, size accumulation, limit check, result register
// depends on hcbd_pkg and hcbd_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module hcbd_back #(
   parameter int COUNT_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  hcbd_pkg::entry_type head_entry,
   input  logic [31:0]         max_body_bytes,
   output logic                pop,
   hcbd_rsp_if.source          rsp_chan
);
   import hcbd_pkg::*;

   localparam int SUM_W = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

   phase_type               phase_ff, phase_in;
   logic [COUNT_BITS-1:0]   chunk_ff, chunk_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    pay_valid_ff;
   logic [7:0]              pay_byte_ff;
   status_type              status_ff;
   logic [31:0]             count_ff;

   phase_type               ph, nph;
   logic [COUNT_BITS-1:0]   chk, nchk, tot, ntot;
   logic [SUM_W-1:0]        size_sum;
   logic                    pv;
   status_type              nstatus;
   logic                    take;

   assign take = !queue_empty && (!rsp_valid_ff || rsp_chan.ready);
   assign pop  = take;

   always_comb begin
      ph  = head_entry.restart ? PHASE_SIZE_START : phase_ff;
      chk = head_entry.restart ? '0 : chunk_ff;
      tot = head_entry.restart ? '0 : total_ff;
      size_sum = SUM_W'(chk) + SUM_W'(tot);
      nph  = ph;
      nchk = chk;
      ntot = tot;
      pv   = 1'b0;
      unique case (ph)
         PHASE_SIZE_START, PHASE_SIZE_DIGITS: begin
            if (head_entry.is_cr) begin
               nph = (ph == PHASE_SIZE_DIGITS) ? PHASE_SIZE_LF : PHASE_BAD;
            end else if (!head_entry.hex_ok) begin
               nph = PHASE_BAD;
            end else if (chk[COUNT_BITS-1 -: 4] != 4'd0) begin
               nph = PHASE_BAD;
            end else begin
               nchk = {chk[COUNT_BITS-5:0], head_entry.hex_val};
               nph  = PHASE_SIZE_DIGITS;
            end
         end
         PHASE_SIZE_LF: begin
            if (!head_entry.is_lf) nph = PHASE_BAD;
            else if (chk == '0) nph = PHASE_FINAL_CR;
            else if (size_sum > SUM_W'(max_body_bytes)) nph = PHASE_BIG;
            else nph = PHASE_DATA;
         end
         PHASE_DATA: begin
            pv   = 1'b1;
            ntot = tot + COUNT_BITS'(1);
            nchk = chk - COUNT_BITS'(1);
            if (chk == COUNT_BITS'(1)) nph = PHASE_DATA_CR;
         end
         PHASE_DATA_CR: begin
            nph = head_entry.is_cr ? PHASE_DATA_LF : PHASE_BAD;
         end
         PHASE_DATA_LF: begin
            if (head_entry.is_lf) begin
               nph  = PHASE_SIZE_START;
               nchk = '0;
            end else begin
               nph = PHASE_BAD;
            end
         end
         PHASE_FINAL_CR: begin
            nph = head_entry.is_cr ? PHASE_FINAL_LF : PHASE_BAD;
         end
         PHASE_FINAL_LF: begin
            nph = head_entry.is_lf ? PHASE_DONE : PHASE_BAD;
         end
         PHASE_DONE, PHASE_BIG: begin
            nph = ph;
         end
         default: begin
            nph = PHASE_BAD;
         end
      endcase

      unique case (nph)
         PHASE_DONE: nstatus = STATUS_DONE;
         PHASE_BAD:  nstatus = STATUS_BAD;
         PHASE_BIG:  nstatus = STATUS_BIG;
         default:    nstatus = STATUS_RUN;
      endcase

      phase_in     = take ? nph : phase_ff;
      chunk_in     = take ? nchk : chunk_ff;
      total_in     = take ? ntot : total_ff;
      rsp_valid_in = take ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_SIZE_START;
         chunk_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         chunk_ff     <= chunk_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pay_valid_ff <= pv;
         pay_byte_ff  <= pv ? head_entry.in_byte : 8'd0;
         status_ff    <= nstatus;
         count_ff     <= 32'(ntot);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.payload_valid = pay_valid_ff;
   assign rsp_chan.payload_byte  = pay_byte_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.body_count    = count_ff;

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_DATA) |-> (chunk_ff != '0))
      else $error("data phase with no bytes left in chunk");

   a_trailer_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_DATA_CR || phase_ff == PHASE_DATA_LF) |-> (chunk_ff == '0))
      else $error("chunk trailer reached with bytes left");

   a_payload_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pay_valid_ff) |-> (status_ff == STATUS_RUN))
      else $error("payload item with a final status");

endmodule

`default_nettype wire

### rtl/http_chunked_body_decoder.sv
// http_chunked_body_decoder: top level of the chunked transfer body decoder
// depends on hcbd_pkg, the three channel interfaces, hcbd_front, hcbd_queue, hcbd_back
// path: an accepted item is written into the queue, and the back moves the queue head into
//    the result register once that register is empty or its result is being accepted
// throughput: one item per cycle while the result side keeps ready high, set by the framing state machine in the back
// reset: synchronous; decoder starts at a new size line, limit register returns to 1048576
// no clearing pass after reset; input and limit writes are held off while reset is high
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder #(
   parameter int COUNT_BITS  = 32,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire          clock,
   input  wire          reset,
   hcbd_req_if.sink     req_chan,
   hcbd_rsp_if.source   rsp_chan,
   hcbd_csr_if.sink     csr_chan
);
   import hcbd_pkg::*;

   // body size limit register; the user must write it only while the decoder is idle, the block does not enforce this
   logic [31:0] max_body_ff, max_body_in;

   // front to queue
   logic      push;
   entry_type push_entry;
   logic      queue_full;

   // queue to back
   logic      pop;
   logic      queue_empty;
   entry_type head_entry;

   // no limit write is taken while reset is high
   assign csr_chan.ready = !reset;

   always_comb begin
      max_body_in = csr_chan.valid ? csr_chan.max_body_bytes : max_body_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= MAX_BODY_RESET;
      end else begin
         max_body_ff <= max_body_in;
      end
   end

   // front: take the byte and tag it as cr, lf or hex digit
   // intake looks full while reset is high so no item is taken then
   hcbd_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full || reset),
      .push       (push),
      .push_entry (push_entry)
   );

   // short queue so a stalled result side does not stop intake at once
   hcbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // back: framing state machine and the result register
   hcbd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .head_entry     (head_entry),
      .max_body_bytes (max_body_ff),
      .pop            (pop),
      .rsp_chan       (rsp_chan)
   );

endmodule

`default_nettype wire

### sim/tb_http_chunked_body_decoder.sv
// tb_http_chunked_body_decoder: self-checking bench for the chunked body decoder
// depends on hcbd_pkg, hcbd_req_if, hcbd_rsp_if, hcbd_csr_if and http_chunked_body_decoder
// drives framed, broken and noisy bodies at random pacing and checks every result item
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
   import hcbd_pkg::*;

   localparam int WATCHDOG_LIMIT  = 1000;  // cycles with no handshake anywhere
   localparam int BYTES_PER_LIMIT = 80;    // at least this many bytes sent per limit setting
   localparam int DRAIN_CYCLES    = 4;     // extra wait after the last result is in, as margin

   // one result item as the decoder should produce it
   typedef struct {
      logic        pv;
      logic [7:0]  pb;
      status_type  st;
      logic [31:0] cnt;
   } body_result_type;

   // shadow of the decoder plus the queue of results still due
   class chunk_decode_board;
      phase_type       phase;
      logic [31:0]     chunk_left;
      logic [31:0]     body_total;
      logic [31:0]     body_limit;
      body_result_type due_q[$];
      int              errors;
      int              checked;
      int              n_payload;
      int              n_done;
      int              n_bad;
      int              n_big;

      function new();
         body_limit = MAX_BODY_RESET;
         restart_body();
         errors    = 0;
         checked   = 0;
         n_payload = 0;
         n_done    = 0;
         n_bad     = 0;
         n_big     = 0;
      endfunction

      function void restart_body();
         phase      = PHASE_SIZE_START;
         chunk_left = '0;
         body_total = '0;
      endfunction

      function void set_limit(input logic [31:0] v);
         body_limit = v;
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 40)
            $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      // decode one accepted byte; returns 1 when the decoder was still framing
      function bit note_byte(input logic [7:0] b, input logic rs);
         body_result_type r;
         bit              live;
         bit              is_hex;
         logic [3:0]      digit;
         if (rs)
            restart_body();
         live = !(phase inside {PHASE_DONE, PHASE_BAD, PHASE_BIG});
         is_hex = 1'b1;
         digit  = '0;
         if (b >= "0" && b <= "9")
            digit = b[3:0];
         else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
            digit = b[3:0] + 4'd9;
         else
            is_hex = 1'b0;
         r.pv = 1'b0;
         r.pb = '0;
         case (phase)
            PHASE_SIZE_START, PHASE_SIZE_DIGITS: begin
               if (b == CH_CR)
                  phase = (phase == PHASE_SIZE_DIGITS) ? PHASE_SIZE_LF : PHASE_BAD;
               else if (!is_hex)
                  phase = PHASE_BAD;
               else if (chunk_left > 32'h0fff_ffff)
                  phase = PHASE_BAD;
               else begin
                  chunk_left = {chunk_left[27:0], digit};
                  phase      = PHASE_SIZE_DIGITS;
               end
            end
            PHASE_SIZE_LF: begin
               if (b != CH_LF)
                  phase = PHASE_BAD;
               else if (chunk_left == 0)
                  phase = PHASE_FINAL_CR;
               else if (body_total > body_limit || chunk_left > body_limit - body_total)
                  phase = PHASE_BIG;
               else
                  phase = PHASE_DATA;
            end
            PHASE_DATA: begin
               r.pv       = 1'b1;
               r.pb       = b;
               body_total = body_total + 32'd1;
               chunk_left = chunk_left - 32'd1;
               if (chunk_left == 0)
                  phase = PHASE_DATA_CR;
            end
            PHASE_DATA_CR:  phase = (b == CH_CR) ? PHASE_DATA_LF : PHASE_BAD;
            PHASE_DATA_LF: begin
               if (b == CH_LF) begin
                  phase      = PHASE_SIZE_START;
                  chunk_left = '0;
               end else begin
                  phase = PHASE_BAD;
               end
            end
            PHASE_FINAL_CR: phase = (b == CH_CR) ? PHASE_FINAL_LF : PHASE_BAD;
            PHASE_FINAL_LF: phase = (b == CH_LF) ? PHASE_DONE : PHASE_BAD;
            PHASE_DONE, PHASE_BIG: ;
            default:        phase = PHASE_BAD;
         endcase
         case (phase)
            PHASE_DONE: r.st = STATUS_DONE;
            PHASE_BAD:  r.st = STATUS_BAD;
            PHASE_BIG:  r.st = STATUS_BIG;
            default:    r.st = STATUS_RUN;
         endcase
         r.cnt = body_total;
         due_q.push_back(r);
         return live;
      endfunction

      task check_result(input logic pv, input logic [7:0] pb, input logic [1:0] st,
                        input logic [31:0] cnt);
         body_result_type e;
         if (due_q.size() == 0) begin
            report($sformatf("result with nothing pending (status %0d count %0d)", st, cnt));
            return;
         end
         e = due_q.pop_front();
         checked++;
         if (pv !== e.pv)
            report($sformatf("result %0d payload_valid %b, want %b", checked, pv, e.pv));
         if (pb !== e.pb)
            report($sformatf("result %0d payload_byte %h, want %h", checked, pb, e.pb));
         if (st !== e.st)
            report($sformatf("result %0d status %0d, want %0d", checked, st, e.st));
         if (cnt !== e.cnt)
            report($sformatf("result %0d body_count %0d, want %0d", checked, cnt, e.cnt));
         if (e.pv) n_payload++;
         case (e.st)
            STATUS_DONE: n_done++;
            STATUS_BAD:  n_bad++;
            STATUS_BIG:  n_big++;
            default: ;
         endcase
      endtask

      task flush_leftovers();
         while (due_q.size() != 0) begin
            void'(due_q.pop_front());
            report("result never arrived");
         end
      endtask
   endclass

   logic clock;
   logic reset;

   hcbd_req_if req_chan ();
   hcbd_rsp_if rsp_chan ();
   hcbd_csr_if csr_chan ();

   http_chunked_body_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   chunk_decode_board board;

   logic [7:0] frame[$];      // bytes of the body being sent
   int         bytes_sent;
   int         live_count;    // bytes the decoder actually framed
   int         limits_used;
   int         burst_left;
   bit         steady;        // no sender gaps while set
   int         stall_left  = 0;
   int         stall_pct   = 0;
   int         mode_left   = 0;
   int         idle_cycles = 0;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- sender side

   // one byte on the request channel, then sender pacing
   task automatic send_item(input logic [7:0] b, input logic rs);
      int gap;
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.restart <= rs;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (board.note_byte(b, rs))
         live_count++;
      bytes_sent++;
      // bursts of random length, random gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = (steady || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // first byte always restarts; later bytes restart with the given percentage
   task automatic send_frame(input int mid_restart_pct);
      foreach (frame[i])
         send_item(frame[i], (i == 0) || ($urandom_range(0, 99) < mid_restart_pct));
   endtask

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         frame.push_back(s[i]);
   endfunction

   function automatic void push_crlf();
      frame.push_back(CH_CR);
      frame.push_back(CH_LF);
   endfunction

   // hex size with random letter case and sometimes a leading zero
   function automatic string size_text(input logic [31:0] v);
      string lo;
      string up;
      lo = $sformatf("%0h", v);
      up = lo.toupper();
      for (int i = 0; i < lo.len(); i++)
         if ($urandom_range(0, 1))
            lo[i] = up[i];
      if ($urandom_range(0, 4) == 0)
         lo = {"0", lo};
      return lo;
   endfunction

   // random body: mostly well formed, some broken, some noise
   task automatic build_random_frame();
      int          kind;
      int          sz;
      int          pos;
      logic [31:0] huge;
      frame.delete();
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         repeat ($urandom_range(0, 4)) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            push_text(size_text(sz));
            push_crlf();
            repeat (sz) frame.push_back(8'($urandom_range(0, 255)));
            push_crlf();
         end
         push_text("0");
         push_crlf();
         push_crlf();
         if (kind >= 70) begin
            // one corrupted byte anywhere in the framing or payload
            pos = $urandom_range(0, frame.size() - 1);
            frame[pos] = 8'($urandom_range(0, 255));
         end else begin
            // trailing bytes after completion are ignored
            repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(0, 255)));
         end
      end else if (kind < 90) begin
         // size that cannot fit in the counter
         push_text($sformatf("%0h", $urandom_range(1, 15)));
         repeat ($urandom_range(8, 9)) push_text($sformatf("%0h", $urandom_range(0, 15)));
         push_crlf();
      end else if (kind < 95) begin
         // huge chunk, cut short by the next restart
         huge = $urandom();
         if (huge == 0) huge = 32'd1;
         push_text(size_text(huge));
         push_crlf();
         repeat ($urandom_range(0, 10)) frame.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // let the decoder go idle, then rewrite the size limit
   task automatic write_limit(input logic [31:0] v);
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_chan.valid          <= 1'b1;
      csr_chan.max_body_bytes <= v;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      board.set_limit(v);
      limits_used++;
   endtask

   // -------------------------------------------------------------- receiver side

   // stalls come in runs of random length; the stall rate is redrawn from 0, 10, 30 and 60 percent at random intervals
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            board.check_result(rsp_chan.payload_valid, rsp_chan.payload_byte,
                               rsp_chan.status, rsp_chan.body_count);
         if (mode_left == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               2:       stall_pct = 30;
               default: stall_pct = 60;
            endcase
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
               stall_left = $urandom_range(1, 10);
         end
      end
   end

   // watchdog: any handshake on any channel resets the count
   always @(posedge clock) begin
      if (reset ||
          (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) ||
          (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ----------------------------------------------------------------- main flow

   logic [31:0] limit_list[6] = '{MAX_BODY_RESET, 32'd37, 32'hffff_ffff, 32'd0, 32'd150, 32'd1};

   initial begin
      int phase_start;
      clock                   = 1'b0;
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.in_byte        = '0;
      req_chan.restart        = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.max_body_bytes = '0;
      bytes_sent  = 0;
      live_count  = 0;
      limits_used = 0;
      burst_left  = 0;
      steady      = 1'b0;
      board = new();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: short body with a full-scale payload byte, then a byte after completion
      frame.delete();
      push_text("1");
      push_crlf();
      frame.push_back(8'hff);
      push_crlf();
      push_text("0");
      push_crlf();
      push_crlf();
      frame.push_back(8'h00);
      send_frame(0);
      // empty size line
      frame.delete();
      frame.push_back(CH_CR);
      send_frame(0);
      // non-hex character in the size
      frame.delete();
      push_text("g");
      send_frame(0);
      // CR not followed by LF on the size line
      frame.delete();
      push_text("a");
      frame.push_back(CH_CR);
      frame.push_back(8'h00);
      send_frame(0);
      // chunk data not followed by CR
      frame.delete();
      push_text("1");
      push_crlf();
      frame.push_back(8'h00);
      frame.push_back(CH_LF);
      send_frame(0);
      // zero size line not followed by CR
      frame.delete();
      push_text("0");
      push_crlf();
      frame.push_back(CH_LF);
      send_frame(0);
      // ninth digit overflows the counter, mixed letter case
      frame.delete();
      push_text("1aBcDeF09");
      send_frame(0);
      // limit of zero: any non-empty chunk is too large
      write_limit(32'd0);
      frame.delete();
      push_text("1");
      push_crlf();
      send_frame(0);

      // random bodies under each limit setting
      foreach (limit_list[k]) begin
         write_limit(limit_list[k]);
         steady      = (k == 2);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_LIMIT) begin
            build_random_frame();
            send_frame(2);
         end
      end

      // drain and finish
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 3) @(posedge clock);
      board.flush_leftovers();

      $display("covered: %0d bytes sent (%0d framed), %0d results checked, %0d limit writes",
               bytes_sent, live_count, board.checked, limits_used);
      $display("results seen: %0d payload, %0d complete, %0d malformed, %0d too large",
               board.n_payload, board.n_done, board.n_bad, board.n_big);
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
rtl/hcbd_pkg.sv
rtl/hcbd_req_if.sv
rtl/hcbd_rsp_if.sv
rtl/hcbd_csr_if.sv
rtl/hcbd_front.sv
rtl/hcbd_queue.sv
rtl/hcbd_back.sv
rtl/http_chunked_body_decoder.sv
sim/tb_http_chunked_body_decoder.sv
